@@ src/bgc_pkg.sv @@
`timescale 1ns / 1ps

package bgc_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned TIME_W    = 32;

    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd700;
    localparam logic [CFG_W-1:0] DOUBLE_WIN_RESET = 16'd350;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS = 2'd0,
        CFG_DOUBLE_WIN = 2'd1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CLICK_NONE   = 2'd0,
        CLICK_SINGLE = 2'd1,
        CLICK_DOUBLE = 2'd2
    } click_t;

    typedef struct packed {
        logic              button_level;
        logic [TIME_W-1:0] now_ms;
    } in_t;

    typedef struct packed {
        logic next_event;
        logic prev_event;
        logic shuffle_event;
        logic shuffle_on;
    } out_t;

    typedef struct packed {
        logic              level_before;
        logic [TIME_W-1:0] press_time;
        logic [TIME_W-1:0] release_time;
        click_t            click_count;
        logic              long_done;
        logic              shuffle_mode;
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] double_window_ms;
    } cfg_t;

endpackage

@@ src/bgc_step.sv @@
`timescale 1ns / 1ps

module bgc_step import bgc_pkg::*; (
    input  state_t state_cur,
    input  cfg_t   cfg,
    input  in_t    item,
    output state_t state_nxt,
    output out_t   result
);

    logic              lvl;
    logic              press_edge;
    logic              release_edge;
    logic [TIME_W-1:0] since_release;
    logic [TIME_W-1:0] press_eff;
    logic [TIME_W-1:0] release_eff;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_release_eff;
    click_t            cc1;
    click_t            cc2;
    click_t            cc3;
    logic              ld1;
    logic              ld2;
    logic              long_hit;
    logic              prev_hit;
    logic              next_hit;

    always_comb begin
        lvl          = item.button_level;
        press_edge   = !state_cur.level_before && lvl;
        release_edge = state_cur.level_before && !lvl;

        // press edge
        since_release = item.now_ms - state_cur.release_time;
        press_eff     = press_edge ? item.now_ms : state_cur.press_time;
        ld1           = press_edge ? 1'b0 : state_cur.long_done;
        if (press_edge) begin
            cc1 = (since_release <= {{(TIME_W-CFG_W){1'b0}}, cfg.double_window_ms})
                ? CLICK_DOUBLE : CLICK_SINGLE;
        end else begin
            cc1 = state_cur.click_count;
        end

        // long press
        held     = item.now_ms - press_eff;
        long_hit = lvl && !ld1 && (held >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms});
        ld2      = ld1 || long_hit;
        cc2      = long_hit ? CLICK_NONE : cc1;

        // release edge
        release_eff = release_edge ? item.now_ms : state_cur.release_time;
        prev_hit    = release_edge && !ld2 && (cc2 == CLICK_DOUBLE);
        cc3         = prev_hit ? CLICK_NONE : cc2;

        // pending single click
        since_release_eff = item.now_ms - release_eff;
        next_hit = (cc3 == CLICK_SINGLE) && !lvl
            && (since_release_eff > {{(TIME_W-CFG_W){1'b0}}, cfg.double_window_ms});

        state_nxt.level_before = lvl;
        state_nxt.press_time   = press_eff;
        state_nxt.release_time = release_eff;
        state_nxt.click_count  = next_hit ? CLICK_NONE : cc3;
        state_nxt.long_done    = ld2;
        state_nxt.shuffle_mode = state_cur.shuffle_mode ^ long_hit;

        result.next_event    = next_hit;
        result.prev_event    = prev_hit;
        result.shuffle_event = long_hit;
        result.shuffle_on    = state_cur.shuffle_mode ^ long_hit;
    end

endmodule

@@ src/button_gesture_classifier_top.sv @@
`timescale 1ns / 1ps
// an input transaction passes through the input register and then the result register
// throughput: one transaction per cycle while no result waits on m_ready; the state update is combinational
// a result waiting on m_ready holds s_ready low only while the input register holds a transaction
// reset: synchronous active-low aresetn clears valids and gesture state,
// loads long_press_ms = 700 and double_window_ms = 350

module button_gesture_classifier_top import bgc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data
);

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    in_t    in_data_reg;
    logic   in_valid_reg;
    out_t   out_data_reg;
    out_t   out_next;
    logic   out_valid_reg;
    logic   advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms    <= LONG_PRESS_RESET;
            cfg_reg.double_window_ms <= DOUBLE_WIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LONG_PRESS: cfg_reg.long_press_ms    <= cfg_wdata;
                CFG_DOUBLE_WIN: cfg_reg.double_window_ms <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    bgc_step u_step (
        .state_cur (state_reg),
        .cfg       (cfg_reg),
        .item      (in_data_reg),
        .state_nxt (state_next),
        .result    (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_next;
        end
    end

    // at most one gesture per transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_data.next_event, m_data.prev_event, m_data.shuffle_event}))
        else $error("more than one gesture in one result");

    // shuffle mode only changes with a shuffle event
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> ((state_reg.shuffle_mode != $past(state_reg.shuffle_mode))
                     == m_data.shuffle_event))
        else $error("shuffle mode changed without shuffle event");

    // click count never holds the unused code
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.click_count == CLICK_NONE) || (state_reg.click_count == CLICK_SINGLE)
            || (state_reg.click_count == CLICK_DOUBLE))
        else $error("illegal click count");

    // input side stalls only behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without output backpressure");

endmodule
